>>> rtl/core/wccr_pkg.sv
// shared constants, types and the srgb linearization table for the contrast checker
// no dependencies; imported by every module of the block
package wccr_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int RATIO_FRAC_BITS = 8;

   localparam int CODE_W  = 8;
   localparam int LIN_W   = FRAC_BITS + 1;
   localparam int LUM_W   = FRAC_BITS + 1;
   localparam int RATIO_W = RATIO_FRAC_BITS + 5;
   localparam int ACC_W   = LUM_W + 14;
   localparam int MIX_W   = LUM_W + 5;
   localparam int NUM_W   = MIX_W + RATIO_FRAC_BITS;
   localparam int DEN_W   = MIX_W;
   localparam int TRY_W   = DEN_W + RATIO_W;

   localparam int RECIP_SHIFT = ACC_W + 4;
   localparam longint unsigned RECIP_VAL = (64'd1 << RECIP_SHIFT) / 64'd10000;
   localparam int RECIP_W  = RECIP_SHIFT - 13;
   localparam int PROD_W   = ACC_W + RECIP_W;

   localparam int LUMA_STAGES = 4;
   localparam int DIV_STAGES  = RATIO_W;
   localparam int NUM_STAGES  = LUMA_STAGES + 1 + DIV_STAGES + 1;

   localparam logic [RATIO_W-1:0] MIN_RATIO_RESET = RATIO_W'((9 << RATIO_FRAC_BITS) / 2);

   typedef logic [LIN_W-1:0] lin_table_type [256];

   typedef struct packed {
      logic [LUM_W-1:0] fg;
      logic [LUM_W-1:0] bg;
   } lum_pair_type;

   function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic longint unsigned q31_pow5(longint unsigned z);
      longint unsigned z2;
      longint unsigned z4;
      z2 = q31_mul(z, z);
      z4 = q31_mul(z2, z2);
      return q31_mul(z4, z);
   endfunction

   function automatic longint unsigned lin_entry(longint unsigned c);
      longint unsigned n, t, s, lo, hi, mid, y, e;
      if (c * 100000 <= 1031475) begin
         return (((c * 5) << (FRAC_BITS + 1)) + 16473) / 32946;
      end
      n = 1000 * c + 14025;
      t = ((n << 32) + 269025) / 538050;
      if (t > (64'd1 << 31)) t = 64'd1 << 31;
      s = q31_mul(t, t);
      lo = 0;
      hi = 64'd1 << 31;
      for (int i = 0; i < 40; i++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (q31_pow5(mid) <= s) lo = mid;
            else hi = mid - 1;
         end
      end
      y = q31_mul(s, lo);
      e = (y + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
      if (e > (64'd1 << FRAC_BITS)) e = 64'd1 << FRAC_BITS;
      return e;
   endfunction

   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      for (int c = 0; c < 256; c++) begin
         tbl[c] = LIN_W'(lin_entry(longint'(c)));
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

>>> rtl/core/wccr_luma.sv
// four-stage relative luminance pipe: table lookup, weighted sum, reciprocal scale, fix-up
// depends on wccr_pkg; stage enables come from the top level
module wccr_luma (
   input  logic                              clock,
   input  logic [wccr_pkg::LUMA_STAGES-1:0]  en,
   input  logic [wccr_pkg::CODE_W-1:0]       red,
   input  logic [wccr_pkg::CODE_W-1:0]       green,
   input  logic [wccr_pkg::CODE_W-1:0]       blue,
   output logic [wccr_pkg::LUM_W-1:0]        luminance
);
   import wccr_pkg::*;

   localparam logic [ACC_W-1:0]   W_RED   = ACC_W'(2126);
   localparam logic [ACC_W-1:0]   W_GREEN = ACC_W'(7152);
   localparam logic [ACC_W-1:0]   W_BLUE  = ACC_W'(722);
   localparam logic [ACC_W-1:0]   HALF    = ACC_W'(5000);
   localparam logic [ACC_W-1:0]   DIVISOR = ACC_W'(10000);
   localparam logic [PROD_W-1:0]  RECIP   = PROD_W'(RECIP_VAL);

   logic [LIN_W-1:0]  r_ff, g_ff, b_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  acc2_ff;
   logic [LUM_W-1:0]  q0_ff, q0_in;
   logic [LUM_W-1:0]  lum_ff, lum_in;
   logic [PROD_W-1:0] prod;
   logic [ACC_W-1:0]  rem;

   always_comb begin
      acc_in = ACC_W'(r_ff) * W_RED + ACC_W'(g_ff) * W_GREEN + ACC_W'(b_ff) * W_BLUE + HALF;
      prod   = PROD_W'(acc_ff) * RECIP;
      q0_in  = LUM_W'(prod >> RECIP_SHIFT);
      rem    = acc2_ff - ACC_W'(q0_ff) * DIVISOR;
      lum_in = (rem >= DIVISOR) ? q0_ff + LUM_W'(1) : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff <= LIN_TABLE[red];
         g_ff <= LIN_TABLE[green];
         b_ff <= LIN_TABLE[blue];
      end
      if (en[1]) acc_ff <= acc_in;
      if (en[2]) begin
         q0_ff   <= q0_in;
         acc2_ff <= acc_ff;
      end
      if (en[3]) lum_ff <= lum_in;
   end

   assign luminance = lum_ff;

endmodule

>>> rtl/core/wccr_div.sv
// restoring divider, one quotient bit per register stage, luminances carried alongside
// depends on wccr_pkg; stage enables come from the top level
module wccr_div (
   input  logic                             clock,
   input  logic [wccr_pkg::DIV_STAGES-1:0]  en,
   input  logic [wccr_pkg::NUM_W-1:0]       num,
   input  logic [wccr_pkg::DEN_W-1:0]       den,
   input  wccr_pkg::lum_pair_type           lums_i,
   output logic [wccr_pkg::RATIO_W-1:0]     quotient,
   output wccr_pkg::lum_pair_type           lums_o
);
   import wccr_pkg::*;

   logic [NUM_W-1:0]   rem_ff  [DIV_STAGES];
   logic [DEN_W-1:0]   den_ff  [DIV_STAGES];
   logic [RATIO_W-1:0] q_ff    [DIV_STAGES];
   lum_pair_type       lums_ff [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [NUM_W-1:0]   rem_src;
      logic [DEN_W-1:0]   den_src;
      logic [RATIO_W-1:0] q_src;
      lum_pair_type       lums_src;
      logic [TRY_W-1:0]   shifted;
      logic [NUM_W-1:0]   rem_in;
      logic [RATIO_W-1:0] q_in;

      if (i == 0) begin : g_first
         assign rem_src  = num;
         assign den_src  = den;
         assign q_src    = '0;
         assign lums_src = lums_i;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign den_src  = den_ff[i-1];
         assign q_src    = q_ff[i-1];
         assign lums_src = lums_ff[i-1];
      end

      always_comb begin
         shifted = TRY_W'(den_src) << (DIV_STAGES - 1 - i);
         rem_in  = rem_src;
         q_in    = q_src;
         if (TRY_W'(rem_src) >= shifted) begin
            rem_in = rem_src - NUM_W'(shifted);
            q_in[DIV_STAGES-1-i] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[i]) begin
            rem_ff[i]  <= rem_in;
            den_ff[i]  <= den_src;
            q_ff[i]    <= q_in;
            lums_ff[i] <= lums_src;
         end
      end
   end

   assign quotient = q_ff[DIV_STAGES-1];
   assign lums_o   = lums_ff[DIV_STAGES-1];

endmodule

>>> rtl/core/wcag_contrast_ratio_check.sv
// top level of the wcag contrast ratio checker: handshake, stage valids, ratio setup, output
// depends on wccr_pkg, wccr_luma and wccr_div
//
// One colour pair per beat goes in and one result beat comes out, with a new pair accepted
// every clock while the pipe is not full and stalled. The pipe has 19 register stages: four
// for the table lookup and luminance, one to order the luminances and form numerator and
// denominator, thirteen for the divider (one quotient bit per stage) and one output register.
// The first stage loads at the accepting edge, and the result beat is offered from the output
// register. Each stage holds its beat only when the stage after it is full and stalled, so
// bubbles close up and a stall at rsp_tready reaches req_tready only once the pipe is full.
// min_ratio is written through the csr port, which is always ready.
module wcag_contrast_ratio_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
   input  logic [47:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // fg_luminance, bg_luminance, ratio, passes
   output logic [47:0]                   rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [wccr_pkg::RATIO_W-1:0]  csr_data
);
   import wccr_pkg::*;

   localparam int PREP = LUMA_STAGES;
   localparam int DIV0 = LUMA_STAGES + 1;
   localparam int OUTS = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] en;
   logic [RATIO_W-1:0]    min_ratio_ff;

   logic [LUM_W-1:0]   fg_lum, bg_lum;
   logic [LUM_W-1:0]   hi, lo;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   lum_pair_type       lums_ff, div_lums;
   logic [RATIO_W-1:0] quotient;
   lum_pair_type       out_lums_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic               passes_ff;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ratio_ff <= MIN_RATIO_RESET;
      end else if (csr_valid) begin
         min_ratio_ff <= csr_data;
      end
   end

   wccr_luma u_fg (
      .clock     (clock),
      .en        (en[LUMA_STAGES-1:0]),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .luminance (fg_lum)
   );

   wccr_luma u_bg (
      .clock     (clock),
      .en        (en[LUMA_STAGES-1:0]),
      .red       (req_tdata[31:24]),
      .green     (req_tdata[39:32]),
      .blue      (req_tdata[47:40]),
      .luminance (bg_lum)
   );

   always_comb begin
      hi     = (fg_lum > bg_lum) ? fg_lum : bg_lum;
      lo     = (fg_lum > bg_lum) ? bg_lum : fg_lum;
      num_in = NUM_W'(MIX_W'(hi) * MIX_W'(20) + (MIX_W'(1) << FRAC_BITS)) << RATIO_FRAC_BITS;
      den_in = DEN_W'(MIX_W'(lo) * MIX_W'(20) + (MIX_W'(1) << FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en[PREP]) begin
         num_ff     <= num_in;
         den_ff     <= den_in;
         lums_ff.fg <= fg_lum;
         lums_ff.bg <= bg_lum;
      end
   end

   wccr_div u_div (
      .clock    (clock),
      .en       (en[OUTS-1:DIV0]),
      .num      (num_ff),
      .den      (den_ff),
      .lums_i   (lums_ff),
      .quotient (quotient),
      .lums_o   (div_lums)
   );

   always_ff @(posedge clock) begin
      if (en[OUTS]) begin
         out_lums_ff <= div_lums;
         ratio_ff    <= quotient;
         passes_ff   <= (quotient >= min_ratio_ff);
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[OUTS];
   assign rsp_tdata  = {passes_ff, ratio_ff, out_lums_ff.bg, out_lums_ff.fg};
   assign csr_ready  = 1'b1;

endmodule

>>> tb/sv/tb_wcag_contrast_ratio_check.sv
// self-checking testbench for wcag_contrast_ratio_check: streams colour pairs and compares
// every result beat with fixed values (directed black/white pairs) or a built-in
// luminance and contrast predictor; depends on wccr_pkg and the rtl of the block
module tb_wcag_contrast_ratio_check;
   timeunit 1ns;
   timeprecision 1ps;
   import wccr_pkg::*;

   typedef struct packed {
      logic [7:0] bg_blue, bg_green, bg_red, fg_blue, fg_green, fg_red;
   } pair_type;

   typedef struct packed {
      logic                 passes;
      logic [RATIO_W-1:0]   ratio;
      logic [LUM_W-1:0]     bg_lum;
      logic [LUM_W-1:0]     fg_lum;
   } verdict_type;

   typedef struct {
      pair_type    colours;
      bit          typed;
      verdict_type want;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [47:0] req_tdata = '0;
   logic [RATIO_W-1:0] csr_data = '0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [47:0] rsp_tdata;

   longint unsigned srgb_lin [256];
   logic [RATIO_W-1:0] threshold;
   verdict_type pending_verdicts[$];
   int errors = 0, idle_cycles = 0, sent = 0, received = 0;
   bit long_hold = 0, stall_free = 0;

   wcag_contrast_ratio_check dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_valid, .csr_ready, .csr_data
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 30)) >> 31;
   endfunction

   function automatic longint unsigned fifth_power(longint unsigned z);
      longint unsigned sq;
      sq = fx_mul(z, z);
      return fx_mul(fx_mul(sq, sq), z);
   endfunction

   function automatic longint unsigned linearize(int code);
      longint unsigned base, sq, lo, hi, mid, y, e;
      if (code <= 10) return ((longint'(code) * 5 << 17) + 16473) / 32946;
      base = ((longint'(1000 * code + 14025) << 32) + 269025) / 538050;
      if (base > (64'd1 << 31)) base = 64'd1 << 31;
      sq = fx_mul(base, base);
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (fifth_power(mid) <= sq) lo = mid;
         else hi = mid - 1;
      end
      y = fx_mul(sq, lo);
      e = (y + (64'd1 << 14)) >> 15;
      return e > 65536 ? 65536 : e;
   endfunction

   function automatic longint unsigned luminance(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      longint unsigned l;
      l = (2126 * srgb_lin[r] + 7152 * srgb_lin[g] + 722 * srgb_lin[b] + 5000) / 10000;
      return l > 65536 ? 65536 : l;
   endfunction

   function automatic verdict_type predict_contrast(pair_type p);
      longint unsigned lf, lb, lh, ld, q;
      verdict_type v;
      lf = luminance(p.fg_red, p.fg_green, p.fg_blue);
      lb = luminance(p.bg_red, p.bg_green, p.bg_blue);
      lh = lf > lb ? lf : lb;
      ld = lf > lb ? lb : lf;
      q = ((20 * lh + 65536) << 8) / (20 * ld + 65536);
      if (q < 256) q = 256;
      if (q > 5376) q = 5376;
      v.fg_lum = LUM_W'(lf);
      v.bg_lum = LUM_W'(lb);
      v.ratio = RATIO_W'(q);
      v.passes = (RATIO_W'(q) >= threshold);
      return v;
   endfunction

   // valid stays up after the beat; idle_gap and drain take it down
   task automatic send_pair(pair_type p, bit typed, verdict_type want);
      req_tvalid <= 1;
      req_tdata <= p;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      pending_verdicts.push_back(typed ? want : predict_contrast(p));
      sent++;
      @(posedge clock);
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain(int extra);
      req_tvalid <= 0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_threshold(logic [RATIO_W-1:0] v);
      csr_valid <= 1;
      csr_data <= v;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      threshold = v;
      @(posedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [7:0] channel_value();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(0, 12));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count);
      pair_type p;
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && count > 0) begin
            p = {channel_value(), channel_value(), channel_value(),
                 channel_value(), channel_value(), channel_value()};
            if ($urandom_range(0, 9) == 0) p[47:24] = p[23:0];
            send_pair(p, 0, '0);
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
   endtask

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(1, 20)) begin
            if (long_hold) break;
            rsp_tready <= stall_free || mode == 0 ? 1'b1 :
                          mode == 1 ? 1'($urandom_range(0, 1)) :
                          mode == 2 ? ($urandom_range(0, 4) != 0) : 1'b0;
            @(posedge clock);
         end
      end
   end

   // result checking and watchdog
   initial begin
      verdict_type got, want;
      forever begin
         @(negedge clock);
         if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
            idle_cycles = 0;
         else if (!reset)
            idle_cycles++;
         if (idle_cycles > 3000) begin
            $display("simulation failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            received++;
            if (pending_verdicts.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_tdata);
               errors++;
            end else begin
               want = pending_verdicts.pop_front();
               if (got.fg_lum !== want.fg_lum) begin
                  $error("fg_luminance expected %0d got %0d", want.fg_lum, got.fg_lum);
                  errors++;
               end
               if (got.bg_lum !== want.bg_lum) begin
                  $error("bg_luminance expected %0d got %0d", want.bg_lum, got.bg_lum);
                  errors++;
               end
               if (got.ratio !== want.ratio) begin
                  $error("ratio expected %0d got %0d", want.ratio, got.ratio);
                  errors++;
               end
               if (got.passes !== want.passes) begin
                  $error("passes expected %0d got %0d", want.passes, got.passes);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      row_type rows[$];
      logic [RATIO_W-1:0] settings[$];
      for (int c = 0; c < 256; c++) srgb_lin[c] = linearize(c);
      threshold = 13'd1152;
      rows = '{
         '{48'h000000_000000, 1, '{1'b0, 13'd256, 17'd0, 17'd0}},
         '{48'hffffff_000000, 1, '{1'b1, 13'd5376, 17'd65536, 17'd0}},
         '{48'h000000_ffffff, 1, '{1'b1, 13'd5376, 17'd0, 17'd65536}},
         '{48'hffffff_ffffff, 1, '{1'b0, 13'd256, 17'd65536, 17'd65536}},
         '{48'h0000ff_0000ff, 0, '0},
         '{48'h00ff00_00ff00, 0, '0},
         '{48'hff0000_ff0000, 0, '0},
         '{48'h000000_0a0a0a, 0, '0},
         '{48'h000000_0b0b0b, 0, '0},
         '{48'h0a0b0a_0b0a0b, 0, '0},
         '{48'h767676_ffffff, 0, '0},
         '{48'h777777_ffffff, 0, '0},
         '{48'hffffff_595959, 0, '0},
         '{48'h0000ff_ffff00, 0, '0},
         '{48'hff00ff_00ff00, 0, '0},
         '{48'h808080_010101, 0, '0},
         '{48'hfefefe_fefefe, 0, '0},
         '{48'h123456_abcdef, 0, '0}
      };
      settings = '{13'd0, 13'd256, 13'd5376, 13'd8191, 13'd700, 13'd255, 13'd5377};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      stall_free = 1;
      foreach (rows[i]) send_pair(rows[i].colours, rows[i].typed, rows[i].want);
      stall_free = 0;
      random_phase(250);
      foreach (settings[k]) begin
         drain(25);
         write_threshold(settings[k]);
         if (k == 1) long_hold = 1;
         random_phase(200);
      end
      drain(25);
      write_threshold(13'($urandom_range(256, 5376)));
      random_phase(100);
      drain(40);
      $display("sent %0d colour pairs over %0d thresholds, %0d results checked",
               sent, settings.size() + 2, received);
      $display("directed black, white and gray pairs plus random pairs under stalls");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
